[hdl/iwm_pkg.sv]
package iwm_pkg;

    // field widths
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned TEMP_W     = 15;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned WIN_W      = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // running sum: at most 255 terms of magnitude 2^14
    localparam int unsigned SUM_W = TEMP_W + WIN_W;

    // divider: dividend covers both |diff| * offset and |sum|
    localparam int unsigned DVD_W      = SUM_W;
    localparam int unsigned DVS_W      = TIME_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DVD_W);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_END,
        CFG_MIN_SAMPLES
    } cfg_index_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_AVERAGED,
        STAT_TOO_FEW,
        STAT_NOT_COVERED,
        STAT_ORDER_ERR
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_START,
        S_DIV_WAIT,
        S_UPDATE,
        S_DECIDE,
        S_MEAN_WAIT,
        S_DONE
    } state_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hdl/iwm_sample_if.sv]
interface iwm_sample_if;
    import iwm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        sample_time;
    logic signed [TEMP_W-1:0] sample_temperature;
    logic                     last_sample;

    modport source (output valid, output sample_time, output sample_temperature,
                    output last_sample, input ready);
    modport sink (input valid, input sample_time, input sample_temperature,
                  input last_sample, output ready);
endinterface

[hdl/iwm_result_if.sv]
interface iwm_result_if;
    import iwm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] ground_temperature;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         samples_seen;

    modport source (output valid, output ground_temperature, output status,
                    output samples_seen, input ready);
    modport sink (input valid, input ground_temperature, input status,
                  input samples_seen, output ready);
endinterface

[hdl/iwm_cfg_if.sv]
interface iwm_cfg_if;
    import iwm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/iwm_div.sv]
module iwm_div (
    input  logic             clk,
    input  logic             rst_n,
    input  iwm_pkg::div_req_t req,
    output iwm_pkg::div_rsp_t rsp
);
    import iwm_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       trial;
    logic                 fits;

    // one restoring step: shift in next dividend bit, try to subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = !trial[DVS_W];
    end

    // step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_LAST;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hdl/interpolated_window_mean.sv]
// channel   dir   payload                                         modport
// sample    in    sample_time, sample_temperature, last_sample    sink
// result    out   ground_temperature, status, samples_seen        source
// cfg       in    index (0 window_end, 1 min_samples), data       sink
//
// an in-order sample passes eval, one divide per interpolated second, then update; any other
// sample passes eval only; each divide is one pass of the shared 23-step restoring divider
// a last sample then goes through decide and, for the mean, one more pass of the divider
// sample ready only when the sequencer is idle; cfg is always ready
// a held result stalls the last cycle until the output register is free,
// then sits there while the next sample is taken
// rst_n clears the sounding state and loads window_end 50, min_samples 100
module interpolated_window_mean #(
    parameter int unsigned MAX_WINDOW = 255
) (
    input logic           clk,
    input logic           rst_n,
    iwm_sample_if.sink    sample,
    iwm_result_if.source  result,
    iwm_cfg_if.sink       cfg
);
    import iwm_pkg::*;

    localparam int unsigned      WIN_CAP   = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
    localparam logic [WIN_W-1:0] WIN_CAP_V = WIN_CAP[WIN_W-1:0];

    // configuration
    logic [WIN_W-1:0]          window_end_reg;
    logic [CNT_W-1:0]          min_samples_reg;

    // sequencer
    state_t                    state_reg;
    state_t                    state_next;

    // latched sample
    logic [TIME_W-1:0]         t_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic                      last_reg;

    // sounding state
    logic [TIME_W-1:0]         first_time_reg;
    logic signed [TEMP_W-1:0]  first_temp_reg;
    logic [TIME_W-1:0]         prev_time_reg;
    logic signed [TEMP_W-1:0]  prev_temp_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      reached_reg;
    logic                      order_err_reg;

    // interpolation loop
    logic [TIME_W-1:0]         span_reg;
    logic [TEMP_W-1:0]         dmag_reg;
    logic                      dneg_reg;
    logic [DVD_W-1:0]          num_reg;
    logic [WIN_W-1:0]          left_reg;

    // pending result and output register
    status_t                   res_status_reg;
    logic signed [TEMP_W-1:0]  res_temp_reg;
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [TEMP_W-1:0]  out_temp_reg;
    logic [CNT_W-1:0]          out_count_reg;

    // datapath nets
    logic [WIN_W-1:0]          win;
    logic [TIME_W-1:0]         win16;
    logic [TIME_W-1:0]         stop16;
    logic                      run;
    logic                      in_order;
    logic signed [TEMP_W:0]    diff;
    logic signed [TEMP_W:0]    diff_abs;
    logic signed [TEMP_W:0]    frac;
    logic signed [SUM_W-1:0]   term_sum;
    logic [SUM_W-1:0]          sum_mag;
    logic [TEMP_W-1:0]         mean_q;
    logic [TEMP_W-1:0]         mean_res;
    logic [WIN_W-1:0]          mean_len;
    logic [CNT_W-1:0]          count_inc;
    status_t                   decide_status;
    logic                      out_free;
    logic                      accept;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    iwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // window, segment bounds and slope
    always_comb
    begin
        win       = (window_end_reg < WIN_CAP_V) ? window_end_reg : WIN_CAP_V;
        win16     = {{(TIME_W - WIN_W){1'b0}}, win};
        stop16    = (t_reg < win16) ? t_reg : win16;
        run       = prev_time_reg < stop16;
        in_order  = t_reg > prev_time_reg;
        diff      = TEMP_W'(0) + ((TEMP_W + 1)'(temp_reg) - (TEMP_W + 1)'(prev_temp_reg));
        diff_abs  = diff[TEMP_W] ? -diff : diff;
        count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
        out_free  = !out_valid_reg || result.ready;
        accept    = sample.valid && (state_reg == S_IDLE);
    end

    // interpolated term and mean from the divider result
    always_comb
    begin
        frac     = dneg_reg ? -$signed({1'b0, div_rsp.quotient[TEMP_W-1:0]})
                            : $signed({1'b0, div_rsp.quotient[TEMP_W-1:0]});
        term_sum = sum_reg + SUM_W'(prev_temp_reg) + SUM_W'(frac);
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mean_q   = div_rsp.quotient[TEMP_W-1:0];
        mean_res = sum_reg[SUM_W-1] ? -mean_q : mean_q;
        mean_len = win - first_time_reg[WIN_W-1:0];
    end

    // status precedence at the end of a sounding
    always_comb
    begin
        if (order_err_reg)
            decide_status = STAT_ORDER_ERR;
        else if (count_reg < min_samples_reg)
            decide_status = STAT_TOO_FEW;
        else if (first_time_reg >= win16 || !reached_reg)
            decide_status = STAT_NOT_COVERED;
        else
            decide_status = STAT_AVERAGED;
    end

    // divider request: interpolation step or final mean
    always_comb
    begin
        div_req.start = (state_reg == S_DIV_START) ||
                        (state_reg == S_DECIDE && decide_status == STAT_AVERAGED);
        if (state_reg == S_DECIDE)
        begin
            div_req.dividend = sum_mag;
            div_req.divisor  = {{(DVS_W - WIN_W){1'b0}}, mean_len};
        end
        else
        begin
            div_req.dividend = num_reg;
            div_req.divisor  = span_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (count_reg == '0 || !in_order)
                    state_next = last_reg ? S_DECIDE : S_IDLE;
                else
                    state_next = run ? S_DIV_START : S_UPDATE;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (left_reg == WIN_W'(1)) ? S_UPDATE : S_DIV_START;
            end
            S_UPDATE:
            begin
                state_next = last_reg ? S_DECIDE : S_IDLE;
            end
            S_DECIDE:
            begin
                state_next = (decide_status == STAT_AVERAGED) ? S_MEAN_WAIT : S_DONE;
            end
            S_MEAN_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        sample.ready              = (state_reg == S_IDLE);
        cfg.ready                 = 1'b1;
        result.valid              = out_valid_reg;
        result.ground_temperature = out_temp_reg;
        result.status             = out_status_reg;
        result.samples_seen       = out_count_reg;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_end_reg  <= WIN_W'(50);
            min_samples_reg <= CNT_W'(100);
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_WINDOW_END:  window_end_reg  <= cfg.data[WIN_W-1:0];
                CFG_MIN_SAMPLES: min_samples_reg <= cfg.data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // sounding state and loop control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= 1'b0;
            first_time_reg <= '0;
            first_temp_reg <= '0;
            prev_time_reg  <= '0;
            prev_temp_reg  <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            reached_reg    <= 1'b0;
            order_err_reg  <= 1'b0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // output register: loaded from the sequencer, emptied by a transfer
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        last_reg <= sample.last_sample;
                end
                S_EVAL:
                begin
                    count_reg <= count_inc;
                    if (count_reg == '0)
                    begin
                        first_time_reg <= t_reg;
                        first_temp_reg <= temp_reg;
                        prev_time_reg  <= t_reg;
                        prev_temp_reg  <= temp_reg;
                    end
                    else if (!in_order)
                        order_err_reg <= 1'b1;
                    else
                        left_reg <= stop16[WIN_W-1:0] - prev_time_reg[WIN_W-1:0];
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        sum_reg  <= term_sum;
                        left_reg <= left_reg - 1'b1;
                    end
                end
                S_UPDATE:
                begin
                    if (t_reg >= win16)
                        reached_reg <= 1'b1;
                    prev_time_reg <= t_reg;
                    prev_temp_reg <= temp_reg;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        first_time_reg <= '0;
                        first_temp_reg <= '0;
                        prev_time_reg  <= '0;
                        prev_temp_reg  <= '0;
                        sum_reg        <= '0;
                        count_reg      <= '0;
                        reached_reg    <= 1'b0;
                        order_err_reg  <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    t_reg    <= sample.sample_time;
                    temp_reg <= sample.sample_temperature;
                end
            end
            S_EVAL:
            begin
                span_reg <= t_reg - prev_time_reg;
                dmag_reg <= diff_abs[TEMP_W-1:0];
                dneg_reg <= diff[TEMP_W];
                num_reg  <= '0;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                    num_reg <= num_reg + DVD_W'(dmag_reg);
            end
            S_DECIDE:
            begin
                res_status_reg <= decide_status;
                res_temp_reg   <= (decide_status == STAT_TOO_FEW) ? first_temp_reg : '0;
            end
            S_MEAN_WAIT:
            begin
                if (div_rsp.done)
                    res_temp_reg <= mean_res;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_temp_reg   <= res_temp_reg;
                    out_count_reg  <= count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    // divider completes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_WAIT || state_reg == S_MEAN_WAIT))
        else $error("divider result outside a wait state");

    // an interpolation step is only issued with seconds left to cover
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_START |-> left_reg != '0)
        else $error("interpolation step with empty range");

    // not-covered and order-error statuses carry a zero temperature
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg != STAT_NOT_COVERED &&
                           out_status_reg != STAT_ORDER_ERR) || out_temp_reg == '0)
        else $error("nonzero temperature on error status");

    // sounding state is cleared once a result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (count_reg == '0 && !order_err_reg &&
                                               out_valid_reg))
        else $error("sounding not cleared after result");
`endif

endmodule
